FILE: hw/rtl/pfr_pkg.sv
// ----------------------------------------------------------------------------
// pfr_pkg
// shared types, codes and helpers of the page frame replacement engine
// ----------------------------------------------------------------------------
package pfr_pkg;

  localparam int FRAMES_DEF = 64;
  localparam int PAGE_W     = 10;
  localparam int FRAME_W    = 6;
  localparam int PERM_W     = 2;
  localparam int STAMP_W    = 32;
  localparam int CNT_W      = 32;
  localparam int LFSR_W     = 16;
  localparam int POL_W      = 2;
  localparam int FIU_W      = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [LFSR_W-1:0] LFSR_MASK = 16'hB400;

  // victim policy codes
  localparam logic [POL_W-1:0] POL_RANDOM = 2'd0;
  localparam logic [POL_W-1:0] POL_FIFO   = 2'd1;
  localparam logic [POL_W-1:0] POL_LRU    = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_POLICY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAMES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SEED   = 2'd2;

  localparam logic [PERM_W-1:0] PERM_NONE = 2'd0;
  localparam logic [PERM_W-1:0] PERM_R    = 2'd1;
  localparam logic [PERM_W-1:0] PERM_RW   = 2'd3;

  // search token handed from cell to cell
  typedef struct packed {
    logic               free_found;
    logic               vic_valid;
    logic [STAMP_W-1:0] vic_stamp;
    logic [PAGE_W-1:0]  vic_owner;
    logic               vic_wr;
  } tok_t;

  // frame update broadcast to the cells
  typedef struct packed {
    logic               en;
    logic               set_stamp;
    logic               writable;
    logic [PAGE_W-1:0]  owner;
    logic [STAMP_W-1:0] stamp;
  } wr_t;

  function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] s);
    logic [LFSR_W-1:0] n;
    n = s[0] ? ((s >> 1) ^ LFSR_MASK) : (s >> 1);
    if (n == '0) begin
      n = LFSR_W'(1);
    end
    return n;
  endfunction

endpackage

FILE: hw/rtl/pfr_cell.sv
// ----------------------------------------------------------------------------
// pfr_cell
// one frame: holds its state and updates the passing search token
// ----------------------------------------------------------------------------
module pfr_cell #(
  parameter int INDEX = 0,
  parameter int IW    = 6,
  parameter int NW    = 7
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [NW-1:0]        n_act,
  input  logic [pfr_pkg::POL_W-1:0] pol,
  input  logic [IW-1:0]        rnd_idx,
  input  pfr_pkg::tok_t        tok_i,
  input  logic [IW-1:0]        free_idx_i,
  input  logic [IW-1:0]        vic_idx_i,
  output pfr_pkg::tok_t        tok_o,
  output logic [IW-1:0]        free_idx_o,
  output logic [IW-1:0]        vic_idx_o,
  input  pfr_pkg::wr_t         wr,
  input  logic [IW-1:0]        wr_idx
);
  import pfr_pkg::*;

  localparam logic [IW-1:0] MY = IW'(INDEX);

  logic               busy_r;
  logic               writable_r;
  logic [STAMP_W-1:0] stamp_r;
  logic [PAGE_W-1:0]  owner_r;
  tok_t               tok_r, tok_nxt;
  logic [IW-1:0]      free_idx_r, free_idx_nxt;
  logic [IW-1:0]      vic_idx_r, vic_idx_nxt;
  logic               act, take_free, take_vic, hit;

  assign act = NW'(INDEX) < n_act;
  assign hit = wr.en && (wr_idx == MY);

  always_comb begin
    take_free = act && !busy_r && !tok_i.free_found;
    case (pol)
      POL_RANDOM: take_vic = act && (MY == rnd_idx);
      POL_LRU:    take_vic = act && (!tok_i.vic_valid || stamp_r <= tok_i.vic_stamp);
      default:    take_vic = act && (!tok_i.vic_valid || stamp_r < tok_i.vic_stamp);
    endcase
    tok_nxt      = tok_i;
    free_idx_nxt = free_idx_i;
    vic_idx_nxt  = vic_idx_i;
    if (take_free) begin
      tok_nxt.free_found = 1'b1;
      free_idx_nxt       = MY;
    end
    if (take_vic) begin
      tok_nxt.vic_valid = 1'b1;
      tok_nxt.vic_stamp = stamp_r;
      tok_nxt.vic_owner = owner_r;
      tok_nxt.vic_wr    = writable_r;
      vic_idx_nxt       = MY;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b0;
      writable_r <= 1'b0;
      stamp_r    <= '0;
    end else if (hit) begin
      busy_r     <= 1'b1;
      writable_r <= wr.writable;
      if (wr.set_stamp) begin
        stamp_r <= wr.stamp;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (hit) begin
      owner_r <= wr.owner;
    end
    tok_r      <= tok_nxt;
    free_idx_r <= free_idx_nxt;
    vic_idx_r  <= vic_idx_nxt;
  end

  assign tok_o      = tok_r;
  assign free_idx_o = free_idx_r;
  assign vic_idx_o  = vic_idx_r;

endmodule

FILE: hw/rtl/pfr_modulo.sv
// ----------------------------------------------------------------------------
// pfr_modulo
// bit-serial remainder of the lfsr word by the active frame count
// ----------------------------------------------------------------------------
module pfr_modulo #(
  parameter int NW = 7
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [pfr_pkg::LFSR_W-1:0] dividend,
  input  logic [NW-1:0]              divisor,
  output logic                       done,
  output logic [NW-1:0]              rem
);
  import pfr_pkg::*;

  localparam int SW = $clog2(LFSR_W + 1);

  logic [SW-1:0]     steps_r, steps_nxt;
  logic [LFSR_W-1:0] sh_r, sh_nxt;
  logic [NW-1:0]     rem_r, rem_nxt;
  logic [NW:0]       trial;

  always_comb begin
    trial     = {rem_r, sh_r[LFSR_W-1]};
    steps_nxt = steps_r;
    sh_nxt    = sh_r;
    rem_nxt   = rem_r;
    if (start) begin
      steps_nxt = SW'(LFSR_W);
      sh_nxt    = dividend;
      rem_nxt   = '0;
    end else if (steps_r != '0) begin
      steps_nxt = steps_r - SW'(1);
      sh_nxt    = sh_r << 1;
      if (trial >= {1'b0, divisor}) begin
        rem_nxt = NW'(trial - {1'b0, divisor});
      end else begin
        rem_nxt = NW'(trial);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      steps_r <= '0;
    end else begin
      steps_r <= steps_nxt;
    end
    sh_r  <= sh_nxt;
    rem_r <= rem_nxt;
  end

  assign done = (steps_r == '0) && !start;
  assign rem  = rem_r;

endmodule

FILE: hw/rtl/page_frame_replacement.sv
// ----------------------------------------------------------------------------
// page_frame_replacement
// page fault handler: free frame search, victim choice and fault statistics
// ----------------------------------------------------------------------------
//  channel  direction  signals
//  in       request    in_valid/in_ready, in_page, in_cur_perm, in_cur_frame
//  out      result     out_valid/out_ready, out_frame .. out_evict_count
//  cfg      write      cfg_we, cfg_index, cfg_wdata
//
//  a fault on a mapped page goes from request to result through the update
//  state, then the result register
//  an unmapped fault first runs the serial remainder of the next lfsr value
//  (load and 16 steps), then the search token walks the chain of frame cells,
//  then come the update state and the result register
//  one request is worked at a time; a finished result waits in the output
//  register while the next request is taken, and the update stalls only if
//  the previous result has not been taken yet
//  reset is synchronous and clears busy, writable and stamp of all frames at once (no clearing pass)
// ----------------------------------------------------------------------------
module page_frame_replacement #(
  parameter int FRAMES = pfr_pkg::FRAMES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [pfr_pkg::PAGE_W-1:0]    in_page,
  input  logic [pfr_pkg::PERM_W-1:0]    in_cur_perm,
  input  logic [pfr_pkg::FRAME_W-1:0]   in_cur_frame,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [pfr_pkg::FRAME_W-1:0]   out_frame,
  output logic [pfr_pkg::PERM_W-1:0]    out_new_perm,
  output logic                          out_read_in,
  output logic                          out_evicted,
  output logic [pfr_pkg::PAGE_W-1:0]    out_evicted_page,
  output logic                          out_write_back,
  output logic [pfr_pkg::CNT_W-1:0]     out_fault_count,
  output logic [pfr_pkg::CNT_W-1:0]     out_read_count,
  output logic [pfr_pkg::CNT_W-1:0]     out_write_count,
  output logic [pfr_pkg::CNT_W-1:0]     out_evict_count,
  input  logic                          cfg_we,
  input  logic [pfr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pfr_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import pfr_pkg::*;

  localparam int IW  = $clog2(FRAMES);
  localparam int NW0 = $clog2(FRAMES + 1);
  localparam int NW  = (NW0 > FIU_W) ? NW0 : FIU_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RAND = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_UPD  = 2'd3;

  // control state
  logic [1:0]         state_r, state_nxt;
  logic [IW-1:0]      cnt_r, cnt_nxt;
  logic [POL_W-1:0]   policy_r;
  logic [FIU_W-1:0]   frames_r;
  logic [LFSR_W-1:0]  lfsr_r, lfsr_spec_r;
  logic [STAMP_W-1:0] stamp_clk_r;
  logic [CNT_W-1:0]   fault_cnt_r, read_cnt_r, write_cnt_r, evict_cnt_r;
  logic               out_valid_r;
  logic [IW-1:0]      rnd_idx_r;

  // request held for the duration of the work
  logic [PAGE_W-1:0]  page_r;
  logic [PERM_W-1:0]  perm_r;
  logic [FRAME_W-1:0] cframe_r;

  // result register
  logic [FRAME_W-1:0] o_frame_r;
  logic [PERM_W-1:0]  o_perm_r;
  logic               o_read_r, o_evict_r, o_wb_r;
  logic [PAGE_W-1:0]  o_epage_r;

  logic               in_acc, commit, unmapped, found, evict, wb, map_ok;
  logic [NW-1:0]      n_act;
  logic [IW-1:0]      fidx;
  logic               mod_start, mod_done;
  logic [NW-1:0]      mod_rem;
  wr_t                wr;
  logic [IW-1:0]      wr_idx;

  // chain of frame cells
  tok_t               tok   [FRAMES+1];
  logic [IW-1:0]      f_idx [FRAMES+1];
  logic [IW-1:0]      v_idx [FRAMES+1];

  // clamp the frame count to 1..FRAMES
  always_comb begin
    if (frames_r == '0) begin
      n_act = NW'(1);
    end else if (NW'(frames_r) > NW'(FRAMES)) begin
      n_act = NW'(FRAMES);
    end else begin
      n_act = NW'(frames_r);
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign mod_start = in_acc && (in_cur_perm == PERM_NONE);

  pfr_modulo #(.NW(NW)) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (lfsr_step(lfsr_r)),
    .divisor  (n_act),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  // token entering the first cell: nothing found yet
  assign tok[0]   = '0;
  assign f_idx[0] = '0;
  assign v_idx[0] = '0;

  for (genvar k = 0; k < FRAMES; k++) begin : g_cell
    pfr_cell #(.INDEX(k), .IW(IW), .NW(NW)) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .n_act      (n_act),
      .pol        (policy_r),
      .rnd_idx    (rnd_idx_r),
      .tok_i      (tok[k]),
      .free_idx_i (f_idx[k]),
      .vic_idx_i  (v_idx[k]),
      .tok_o      (tok[k+1]),
      .free_idx_o (f_idx[k+1]),
      .vic_idx_o  (v_idx[k+1]),
      .wr         (wr),
      .wr_idx     (wr_idx)
    );
  end

  // outcome of the walk, read from the end of the chain
  assign unmapped = (perm_r == PERM_NONE);
  assign found    = tok[FRAMES].free_found;
  assign evict    = unmapped && !found;
  assign wb       = evict && tok[FRAMES].vic_wr;
  assign fidx     = found ? f_idx[FRAMES] : v_idx[FRAMES];
  assign map_ok   = NW'(cframe_r) < n_act;
  assign commit   = (state_r == S_UPD) && (!out_valid_r || out_ready);

  // frame update issued in the commit cycle
  always_comb begin
    wr = '0;
    wr_idx = '0;
    if (commit) begin
      wr.owner = page_r;
      wr.stamp = stamp_clk_r;
      if (unmapped) begin
        wr.en        = 1'b1;
        wr.set_stamp = 1'b1;
        wr.writable  = 1'b0;
        wr_idx       = fidx;
      end else begin
        wr.en        = map_ok;
        wr.set_stamp = (policy_r == POL_LRU);
        wr.writable  = 1'b1;
        wr_idx       = IW'(cframe_r);
      end
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = (in_cur_perm == PERM_NONE) ? S_RAND : S_UPD;
        end
      end
      S_RAND: begin
        if (mod_done) begin
          state_nxt = S_SCAN;
          cnt_nxt   = '0;
        end
      end
      S_SCAN: begin
        cnt_nxt = cnt_r + IW'(1);
        if (cnt_r == IW'(FRAMES - 1)) begin
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        if (commit) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      policy_r    <= POL_FIFO;
      frames_r    <= FIU_W'(64);
      lfsr_r      <= LFSR_W'(1);
      stamp_clk_r <= '0;
      fault_cnt_r <= '0;
      read_cnt_r  <= '0;
      write_cnt_r <= '0;
      evict_cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_POLICY: policy_r <= cfg_wdata[POL_W-1:0];
          REG_FRAMES: frames_r <= cfg_wdata[FIU_W-1:0];
          REG_SEED:   lfsr_r   <= (cfg_wdata == '0) ? LFSR_W'(1) : cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (commit) begin
        out_valid_r <= 1'b1;
        if (stamp_clk_r != '1) stamp_clk_r <= stamp_clk_r + 1'b1;
        if (fault_cnt_r != '1) fault_cnt_r <= fault_cnt_r + 1'b1;
        if (unmapped && read_cnt_r != '1) read_cnt_r <= read_cnt_r + 1'b1;
        if (evict && evict_cnt_r != '1) evict_cnt_r <= evict_cnt_r + 1'b1;
        if (wb && write_cnt_r != '1) write_cnt_r <= write_cnt_r + 1'b1;
        // apart from a seed write, the lfsr only moves when a random victim is really taken
        if (evict && policy_r == POL_RANDOM) lfsr_r <= lfsr_spec_r;
      end
    end
  end

  // request capture, speculative lfsr value, random index and result payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      page_r      <= in_page;
      perm_r      <= in_cur_perm;
      cframe_r    <= in_cur_frame;
      lfsr_spec_r <= lfsr_step(lfsr_r);
    end
    if (state_r == S_RAND && mod_done) begin
      rnd_idx_r <= IW'(mod_rem);
    end
    if (commit) begin
      o_frame_r <= unmapped ? FRAME_W'(fidx) : cframe_r;
      o_perm_r  <= unmapped ? PERM_R : PERM_RW;
      o_read_r  <= unmapped;
      o_evict_r <= evict;
      o_epage_r <= evict ? tok[FRAMES].vic_owner : '0;
      o_wb_r    <= wb;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_frame        = o_frame_r;
  assign out_new_perm     = o_perm_r;
  assign out_read_in      = o_read_r;
  assign out_evicted      = o_evict_r;
  assign out_evicted_page = o_epage_r;
  assign out_write_back   = o_wb_r;
  assign out_fault_count  = fault_cnt_r;
  assign out_read_count   = read_cnt_r;
  assign out_write_count  = write_cnt_r;
  assign out_evict_count  = evict_cnt_r;

`ifndef NO_ASSERTIONS
  a_wr_only_commit: assert property (@(posedge clk) disable iff (!rst_n)
    wr.en |-> (state_r == S_UPD)) else $error("frame write outside update");
  a_fault_mono: assert property (@(posedge clk) disable iff (!rst_n)
    ##1 (fault_cnt_r >= $past(fault_cnt_r))) else $error("fault count fell");
  a_evict_read: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && o_evict_r) |-> o_read_r) else $error("eviction without read");
  a_wb_evict: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && o_wb_r) |-> o_evict_r) else $error("write-back without eviction");
  a_commit_frees: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> out_valid_r) else $error("result lost at commit");
`endif

endmodule
